// ----- src/fly_camera_pose_update_unit_assert.svh -----
// Assertion macros for the checker file of the fly camera pose unit.
`ifndef FLY_CAMERA_POSE_UPDATE_UNIT_ASSERT_SVH
`define FLY_CAMERA_POSE_UPDATE_UNIT_ASSERT_SVH
// Same-cycle implication; the consequent may carry its own ## delay.
`define FCP_ASSERT_THEN(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) \
      else $error(msg);
// Next-cycle implication.
`define FCP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- src/fcp_pkg.sv -----
// Types, codes and constants of the fly camera pose unit.
`timescale 1ns / 1ps
package fcp_pkg;
   typedef logic        [1:0]  func_type;
   typedef logic        [2:0]  csr_idx_type;
   typedef logic        [15:0] csr_data_type;
   typedef logic signed [15:0] angle_type;
   typedef logic signed [15:0] vec_type;
   typedef logic signed [31:0] pos_type;
   typedef logic signed [33:0] cord_type;
   typedef logic signed [19:0] cz_type;
   typedef logic signed [33:0] mul_a_type;
   typedef logic signed [17:0] mul_b_type;
   typedef logic signed [51:0] mul_p_type;

   localparam func_type FUNC_MOVE      = 2'd0;
   localparam func_type FUNC_TURN      = 2'd1;
   localparam func_type FUNC_SET_YAW   = 2'd2;
   localparam func_type FUNC_SET_PITCH = 2'd3;

   localparam csr_idx_type CSR_MOVE_SPEED = 3'd0;
   localparam csr_idx_type CSR_TURN_SPEED = 3'd1;
   localparam csr_idx_type CSR_WORLD_UP_X = 3'd2;
   localparam csr_idx_type CSR_WORLD_UP_Y = 3'd3;
   localparam csr_idx_type CSR_WORLD_UP_Z = 3'd4;

   localparam cord_type CORDIC_K     = 34'sd652032874;
   localparam cz_type   HALF_PI_Q16  = 20'sd102944;
   localparam cz_type   PI_Q16       = 20'sd205887;
   localparam int       PI_Q13       = 25736;
   localparam int       TWO_PI_Q13   = 51472;
   localparam int       PITCH_LIMIT  = 12725;

   // Arctangent of 2^-i in Q16 radians.
   function automatic cz_type atan_q16(input logic [3:0] i);
      cz_type a;
      case (i)
         4'd0:  a = 20'sd51472;
         4'd1:  a = 20'sd30386;
         4'd2:  a = 20'sd16055;
         4'd3:  a = 20'sd8150;
         4'd4:  a = 20'sd4091;
         4'd5:  a = 20'sd2047;
         4'd6:  a = 20'sd1024;
         4'd7:  a = 20'sd512;
         4'd8:  a = 20'sd256;
         4'd9:  a = 20'sd128;
         4'd10: a = 20'sd64;
         4'd11: a = 20'sd32;
         4'd12: a = 20'sd16;
         4'd13: a = 20'sd8;
         4'd14: a = 20'sd4;
         default: a = 20'sd2;
      endcase
      return a;
   endfunction
endpackage

// ----- src/fcp_intf.sv -----
// Channel interfaces of the fly camera pose unit: request, response and register write.
`timescale 1ns / 1ps
interface fcp_req_if import fcp_pkg::*; ();
   logic        valid;
   logic        ready;
   func_type    func;
   logic        key_forward;
   logic        key_left;
   logic        key_back;
   logic        key_strafe_right;
   logic [15:0] delta_time;
   angle_type   mouse_dx;
   angle_type   mouse_dy;
   angle_type   angle;
   modport source (output valid, func, key_forward, key_left, key_back, key_strafe_right,
                   delta_time, mouse_dx, mouse_dy, angle, input ready);
   modport sink (input valid, func, key_forward, key_left, key_back, key_strafe_right,
                 delta_time, mouse_dx, mouse_dy, angle, output ready);
endinterface

interface fcp_rsp_if import fcp_pkg::*; ();
   logic    valid;
   logic    ready;
   pos_type pos_x, pos_y, pos_z;
   vec_type front_x, front_y, front_z;
   vec_type right_x, right_y, right_z;
   vec_type up_x, up_y, up_z;
   modport source (output valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                   right_x, right_y, right_z, up_x, up_y, up_z, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                 right_x, right_y, right_z, up_x, up_y, up_z, output ready);
endinterface

interface fcp_csr_if import fcp_pkg::*; ();
   logic         valid;
   logic         ready;
   csr_idx_type  index;
   csr_data_type data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- src/fcp_mul.sv -----
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
module fcp_mul import fcp_pkg::*; (
   input  logic      clock,
   input  mul_a_type mul_a,
   input  mul_b_type mul_b,
   output mul_p_type prod_ff
);
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end
endmodule

// ----- src/fly_camera_pose_update_unit.sv -----
// Top level of the fly camera pose unit: sequencer, state and shared datapath.
`timescale 1ns / 1ps
//
//   Channel   Direction   Carries
//   req_ch    in          one command: move step, mouse turn, set yaw or set pitch
//   rsp_ch    out         position plus front, right and up vectors after the command
//   csr_ch    in          register writes: speeds and world up vector
//
// A set command runs two CORDIC rotations (yaw, then pitch), the front products, and
// for each of the two cross products its products and squares, a 32-step square root
// and three divisions, then loads the result register. A move step adds the position
// update, and a mouse turn adds the mouse delta multiplies and a wrap of the yaw.
// A degenerate cross product skips its square root and divisions. req_ch is ready
// only while the sequencer is idle, which it enters as the result register is loaded.
// Reset is synchronous; it clears position and angles, restores the register defaults
// and drops the output valid.
// A finished result waits in the output register, and the next transaction is taken
// meanwhile; the sequencer only stalls at its end if the previous result is still held.
module fly_camera_pose_update_unit import fcp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   fcp_req_if.sink  req_ch,
   fcp_rsp_if.source rsp_ch,
   fcp_csr_if.sink  csr_ch
);
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_TURN   = 4'd1;
   localparam logic [3:0] ST_WRAP   = 4'd2;
   localparam logic [3:0] ST_CINIT  = 4'd3;
   localparam logic [3:0] ST_CITER  = 4'd4;
   localparam logic [3:0] ST_FRONT  = 4'd5;
   localparam logic [3:0] ST_CROSS  = 4'd6;
   localparam logic [3:0] ST_SQUARE = 4'd7;
   localparam logic [3:0] ST_SQRT   = 4'd8;
   localparam logic [3:0] ST_DSETUP = 4'd9;
   localparam logic [3:0] ST_DITER  = 4'd10;
   localparam logic [3:0] ST_MOVE   = 4'd11;
   localparam logic [3:0] ST_DONE   = 4'd12;

   // Yaw is offset by pi and by a large multiple of 2 pi so the wrap works on a
   // non-negative value with restoring subtracts only.
   localparam logic signed [31:0] WRAP_BIAS = 32'(PI_Q13) + (32'(TWO_PI_Q13) <<< 13);

   logic [3:0]   state_ff;
   logic [5:0]   cnt_ff;
   logic [15:0]  move_speed_ff, turn_speed_ff;
   vec_type      wup_ff [3];
   angle_type    yaw_ff, pitch_ff;
   pos_type      pos_ff [3];
   func_type     func_ff;
   logic         kf_ff, kl_ff, kb_ff, kr_ff;
   logic [15:0]  dt_ff;
   angle_type    mdx_ff, mdy_ff;
   logic [30:0]  wrap_ff;
   cord_type     cx_ff, cy_ff;
   cz_type       cz_ff;
   logic         flip_ff, csel_ff;
   cord_type     cos_yaw_ff, sin_yaw_ff, cos_pitch_ff, sin_pitch_ff;
   logic signed [65:0] acc_ff;
   vec_type      f_ff [3], r_ff [3], u_ff [3];
   logic         pass_ff;
   logic signed [32:0] c_ff [3];
   logic [63:0]  sq_v_ff, sq_r_ff;
   logic [31:0]  norm_ff;
   logic [1:0]   comp_ff;
   logic [46:0]  rem_ff;
   logic [14:0]  quo_ff;
   logic [31:0]  scale_ff;
   logic         rsp_valid_ff;
   pos_type      rsp_pos_ff [3];
   vec_type      rsp_f_ff [3], rsp_r_ff [3], rsp_u_ff [3];

   mul_a_type mul_a;
   mul_b_type mul_b;
   mul_p_type prod_ff;

   fcp_mul u_mul (.clock(clock), .mul_a(mul_a), .mul_b(mul_b), .prod_ff(prod_ff));

   // Cross product operands: right = front x world_up, up = right x front.
   vec_type xa [3], xb [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         xa[i] = pass_ff ? r_ff[i] : f_ff[i];
         xb[i] = pass_ff ? f_ff[i] : wup_ff[i];
      end
   end

   // Component selects for the squaring and the division.
   logic signed [32:0] sqc, dvc;
   always_comb begin
      case (cnt_ff[2:1])
         2'd0:    sqc = c_ff[0];
         2'd1:    sqc = c_ff[1];
         default: sqc = c_ff[2];
      endcase
      case (comp_ff)
         2'd0:    dvc = c_ff[0];
         2'd1:    dvc = c_ff[1];
         default: dvc = c_ff[2];
      endcase
   end

   logic [2:0] mv_issue;
   assign mv_issue = cnt_ff[2:0] - 3'd2;

   // Operand steering for the shared multiplier. Wide factors are split into a
   // signed high part and an unsigned 17-bit low part over two issues.
   cord_type front_src;
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      front_src = cnt_ff[1] ? sin_yaw_ff : cos_yaw_ff;
      unique case (state_ff)
         ST_TURN: begin
            mul_a = mul_a_type'(cnt_ff[0] ? mdy_ff : mdx_ff);
            mul_b = signed'({2'b00, turn_speed_ff});
         end
         ST_FRONT: begin
            mul_a = cos_pitch_ff;
            mul_b = cnt_ff[0] ? signed'({1'b0, front_src[16:0]})
                              : mul_b_type'(front_src >>> 17);
         end
         ST_CROSS: begin
            case (cnt_ff[2:0])
               3'd0: begin mul_a = mul_a_type'(xa[1]); mul_b = mul_b_type'(xb[2]); end
               3'd1: begin mul_a = mul_a_type'(xa[2]); mul_b = mul_b_type'(xb[1]); end
               3'd2: begin mul_a = mul_a_type'(xa[2]); mul_b = mul_b_type'(xb[0]); end
               3'd3: begin mul_a = mul_a_type'(xa[0]); mul_b = mul_b_type'(xb[2]); end
               3'd4: begin mul_a = mul_a_type'(xa[0]); mul_b = mul_b_type'(xb[1]); end
               3'd5: begin mul_a = mul_a_type'(xa[1]); mul_b = mul_b_type'(xb[0]); end
               default: ;
            endcase
         end
         ST_SQUARE: begin
            mul_a = mul_a_type'(sqc);
            mul_b = cnt_ff[0] ? signed'({1'b0, sqc[16:0]}) : mul_b_type'(sqc >>> 17);
         end
         ST_MOVE: begin
            if (cnt_ff == 6'd0) begin
               mul_a = signed'({18'd0, dt_ff});
               mul_b = signed'({2'b00, move_speed_ff});
            end else if (cnt_ff >= 6'd2 && cnt_ff <= 6'd7) begin
               mul_a = signed'({2'b00, scale_ff});
               case (mv_issue)
                  3'd0:    mul_b = mul_b_type'(f_ff[0]);
                  3'd1:    mul_b = mul_b_type'(r_ff[0]);
                  3'd2:    mul_b = mul_b_type'(f_ff[1]);
                  3'd3:    mul_b = mul_b_type'(r_ff[1]);
                  3'd4:    mul_b = mul_b_type'(f_ff[2]);
                  default: mul_b = mul_b_type'(r_ff[2]);
               endcase
            end
         end
         default: ;
      endcase
   end

   // Mouse turn.
   mul_p_type          turn_d;
   logic signed [31:0] yaw_sum, pitch_sum;
   angle_type          pitch_clamp;
   logic [3:0]         wrap_k;
   logic [30:0]        wrap_sub;
   always_comb begin
      turn_d    = (prod_ff + 52'sd4) >>> 3;
      yaw_sum   = 32'(yaw_ff) + 32'(turn_d) + WRAP_BIAS;
      pitch_sum = 32'(pitch_ff) + 32'(turn_d);
      if (pitch_sum >= 32'(PITCH_LIMIT))       pitch_clamp = 16'(PITCH_LIMIT);
      else if (pitch_sum <= -32'(PITCH_LIMIT)) pitch_clamp = -16'(PITCH_LIMIT);
      else                                     pitch_clamp = 16'(pitch_sum);
      wrap_k   = 4'd13 - cnt_ff[3:0];
      wrap_sub = 31'(TWO_PI_Q13) << wrap_k;
   end

   // CORDIC rotation step.
   angle_type cin_ang;
   cz_type    cz0, cz0_red, cat;
   logic      flip0;
   cord_type  cdx, cdy, cx_nx, cy_nx;
   cz_type    cz_nx;
   always_comb begin
      cin_ang = csel_ff ? pitch_ff : yaw_ff;
      cz0     = cz_type'(cin_ang) <<< 3;
      flip0   = 1'b0;
      cz0_red = cz0;
      if (cz0 > HALF_PI_Q16) begin
         cz0_red = cz0 - PI_Q16;
         flip0   = 1'b1;
      end else if (cz0 < -HALF_PI_Q16) begin
         cz0_red = cz0 + PI_Q16;
         flip0   = 1'b1;
      end
      cdx = cy_ff >>> cnt_ff[3:0];
      cdy = cx_ff >>> cnt_ff[3:0];
      cat = atan_q16(cnt_ff[3:0]);
      if (!cz_ff[19]) begin
         cx_nx = cx_ff - cdx;
         cy_nx = cy_ff + cdy;
         cz_nx = cz_ff - cat;
      end else begin
         cx_nx = cx_ff + cdx;
         cy_nx = cy_ff - cdy;
         cz_nx = cz_ff + cat;
      end
   end

   // Front rounding, square root and division steps, move step.
   logic signed [65:0] acc_sum, acc_hi, front_rnd;
   cord_type           fy_rnd;
   logic [2:0]         xi, mv_i;
   logic [63:0]        sq_bit, sq_t;
   logic               sq_ge;
   logic [63:0]        sq_v_nx, sq_r_nx;
   logic [32:0]        dv_mag;
   logic [3:0]         div_k;
   logic [46:0]        dsub;
   logic               div_ge;
   logic [14:0]        div_q;
   vec_type            div_res;
   logic [31:0]        mv_step;
   mul_p_type          mv_rnd;
   always_comb begin
      acc_sum   = acc_ff + 66'(prod_ff);
      acc_hi    = 66'(prod_ff) <<< 17;
      front_rnd = (acc_sum + (66'sd1 <<< 45)) >>> 46;
      fy_rnd    = (sin_pitch_ff + (34'sd1 <<< 15)) >>> 16;
      xi        = cnt_ff[2:0] - 3'd1;
      mv_i      = cnt_ff[2:0] - 3'd3;
      sq_bit    = 64'd1 << (6'd62 - {cnt_ff[4:0], 1'b0});
      sq_t      = sq_r_ff + sq_bit;
      sq_ge     = sq_v_ff >= sq_t;
      sq_v_nx   = sq_ge ? sq_v_ff - sq_t : sq_v_ff;
      sq_r_nx   = sq_ge ? (sq_r_ff >> 1) + sq_bit : sq_r_ff >> 1;
      dv_mag    = dvc[32] ? 33'(-dvc) : 33'(dvc);
      div_k     = 4'd14 - cnt_ff[3:0];
      dsub      = 47'(norm_ff) << div_k;
      div_ge    = rem_ff >= dsub;
      div_q     = {quo_ff[13:0], div_ge};
      div_res   = dvc[32] ? -vec_type'({1'b0, div_q}) : vec_type'({1'b0, div_q});
      mv_rnd    = (prod_ff + (52'sd1 <<< 21)) >>> 22;
      mv_step   = 32'(mv_rnd);
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.pos_x   = rsp_pos_ff[0];
   assign rsp_ch.pos_y   = rsp_pos_ff[1];
   assign rsp_ch.pos_z   = rsp_pos_ff[2];
   assign rsp_ch.front_x = rsp_f_ff[0];
   assign rsp_ch.front_y = rsp_f_ff[1];
   assign rsp_ch.front_z = rsp_f_ff[2];
   assign rsp_ch.right_x = rsp_r_ff[0];
   assign rsp_ch.right_y = rsp_r_ff[1];
   assign rsp_ch.right_z = rsp_r_ff[2];
   assign rsp_ch.up_x    = rsp_u_ff[0];
   assign rsp_ch.up_y    = rsp_u_ff[1];
   assign rsp_ch.up_z    = rsp_u_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         move_speed_ff <= 16'd256;
         turn_speed_ff <= 16'd33;
         wup_ff[0]     <= 16'sd0;
         wup_ff[1]     <= 16'sd16384;
         wup_ff[2]     <= 16'sd0;
         pos_ff[0]     <= '0;
         pos_ff[1]     <= '0;
         pos_ff[2]     <= '0;
         yaw_ff        <= '0;
         pitch_ff      <= '0;
      end else begin
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               CSR_MOVE_SPEED: move_speed_ff <= csr_ch.data;
               CSR_TURN_SPEED: turn_speed_ff <= csr_ch.data;
               CSR_WORLD_UP_X: wup_ff[0] <= signed'(csr_ch.data);
               CSR_WORLD_UP_Y: wup_ff[1] <= signed'(csr_ch.data);
               CSR_WORLD_UP_Z: wup_ff[2] <= signed'(csr_ch.data);
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp_ch.ready) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  func_ff <= req_ch.func;
                  kf_ff   <= req_ch.key_forward;
                  kl_ff   <= req_ch.key_left;
                  kb_ff   <= req_ch.key_back;
                  kr_ff   <= req_ch.key_strafe_right;
                  dt_ff   <= req_ch.delta_time;
                  mdx_ff  <= req_ch.mouse_dx;
                  mdy_ff  <= req_ch.mouse_dy;
                  if (req_ch.func == FUNC_SET_YAW)   yaw_ff   <= req_ch.angle;
                  if (req_ch.func == FUNC_SET_PITCH) pitch_ff <= req_ch.angle;
                  cnt_ff  <= '0;
                  csel_ff <= 1'b0;
                  state_ff <= (req_ch.func == FUNC_TURN) ? ST_TURN : ST_CINIT;
               end
            end
            ST_TURN: begin
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd1) wrap_ff <= 31'(yaw_sum);
               if (cnt_ff == 6'd2) begin
                  pitch_ff <= pitch_clamp;
                  cnt_ff   <= '0;
                  state_ff <= ST_WRAP;
               end
            end
            ST_WRAP: begin
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd14) begin
                  yaw_ff   <= 16'(wrap_ff - 31'(PI_Q13));
                  state_ff <= ST_CINIT;
               end else if (wrap_ff >= wrap_sub) begin
                  wrap_ff <= wrap_ff - wrap_sub;
               end
            end
            ST_CINIT: begin
               cx_ff    <= CORDIC_K;
               cy_ff    <= '0;
               cz_ff    <= cz0_red;
               flip_ff  <= flip0;
               cnt_ff   <= '0;
               state_ff <= ST_CITER;
            end
            ST_CITER: begin
               cx_ff  <= cx_nx;
               cy_ff  <= cy_nx;
               cz_ff  <= cz_nx;
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd15) begin
                  cnt_ff <= '0;
                  if (!csel_ff) begin
                     cos_yaw_ff <= flip_ff ? -cx_nx : cx_nx;
                     sin_yaw_ff <= flip_ff ? -cy_nx : cy_nx;
                     csel_ff    <= 1'b1;
                     state_ff   <= ST_CINIT;
                  end else begin
                     cos_pitch_ff <= flip_ff ? -cx_nx : cx_nx;
                     sin_pitch_ff <= flip_ff ? -cy_nx : cy_nx;
                     state_ff     <= ST_FRONT;
                  end
               end
            end
            ST_FRONT: begin
               cnt_ff <= cnt_ff + 6'd1;
               case (cnt_ff[2:0])
                  3'd1, 3'd3: acc_ff <= acc_hi;
                  3'd2: f_ff[0] <= 16'(front_rnd);
                  3'd4: begin
                     f_ff[2]  <= 16'(front_rnd);
                     f_ff[1]  <= 16'(fy_rnd);
                     pass_ff  <= 1'b0;
                     cnt_ff   <= '0;
                     state_ff <= ST_CROSS;
                  end
                  default: ;
               endcase
            end
            ST_CROSS: begin
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff != 6'd0) begin
                  case (xi)
                     3'd0: c_ff[0] <= 33'(prod_ff);
                     3'd1: c_ff[0] <= c_ff[0] - 33'(prod_ff);
                     3'd2: c_ff[1] <= 33'(prod_ff);
                     3'd3: c_ff[1] <= c_ff[1] - 33'(prod_ff);
                     3'd4: c_ff[2] <= 33'(prod_ff);
                     default: c_ff[2] <= c_ff[2] - 33'(prod_ff);
                  endcase
               end
               if (cnt_ff == 6'd6) begin
                  acc_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= ST_SQUARE;
               end
            end
            ST_SQUARE: begin
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff != 6'd0) acc_ff <= xi[0] ? acc_sum : acc_ff + acc_hi;
               if (cnt_ff == 6'd6) begin
                  sq_v_ff <= acc_sum[63:0];
                  sq_r_ff <= '0;
                  comp_ff <= '0;
                  cnt_ff  <= '0;
                  if (acc_sum[63:0] == 64'd0) begin
                     // Degenerate cross product: the vector comes out all zero.
                     for (int i = 0; i < 3; i++) begin
                        if (pass_ff) u_ff[i] <= '0;
                        else         r_ff[i] <= '0;
                     end
                     if (!pass_ff) begin
                        pass_ff  <= 1'b1;
                        state_ff <= ST_CROSS;
                     end else begin
                        state_ff <= (func_ff == FUNC_MOVE) ? ST_MOVE : ST_DONE;
                     end
                  end else begin
                     state_ff <= ST_SQRT;
                  end
               end
            end
            ST_SQRT: begin
               sq_v_ff <= sq_v_nx;
               sq_r_ff <= sq_r_nx;
               cnt_ff  <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd31) begin
                  norm_ff  <= sq_r_nx[31:0];
                  state_ff <= ST_DSETUP;
               end
            end
            ST_DSETUP: begin
               rem_ff   <= {dv_mag[32:0], 14'd0} + 47'(norm_ff >> 1);
               quo_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= ST_DITER;
            end
            ST_DITER: begin
               cnt_ff <= cnt_ff + 6'd1;
               quo_ff <= div_q;
               if (div_ge) rem_ff <= rem_ff - dsub;
               if (cnt_ff == 6'd14) begin
                  if (pass_ff) u_ff[comp_ff] <= div_res;
                  else         r_ff[comp_ff] <= div_res;
                  cnt_ff <= '0;
                  if (comp_ff != 2'd2) begin
                     comp_ff  <= comp_ff + 2'd1;
                     state_ff <= ST_DSETUP;
                  end else if (!pass_ff) begin
                     pass_ff  <= 1'b1;
                     state_ff <= ST_CROSS;
                  end else begin
                     state_ff <= (func_ff == FUNC_MOVE) ? ST_MOVE : ST_DONE;
                  end
               end
            end
            ST_MOVE: begin
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd1) scale_ff <= prod_ff[31:0];
               if (cnt_ff >= 6'd3) begin
                  // Even products are front steps, odd ones right steps.
                  pos_ff[mv_i[2:1]] <= pos_ff[mv_i[2:1]]
                     + ((mv_i[0] ? kr_ff : kf_ff) ? mv_step : 32'd0)
                     - ((mv_i[0] ? kl_ff : kb_ff) ? mv_step : 32'd0);
               end
               if (cnt_ff == 6'd8) state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  for (int i = 0; i < 3; i++) begin
                     rsp_pos_ff[i] <= pos_ff[i];
                     rsp_f_ff[i]   <= f_ff[i];
                     rsp_r_ff[i]   <= r_ff[i];
                     rsp_u_ff[i]   <= u_ff[i];
                  end
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// ----- src/fcp_checker.sv -----
// Port-level checker for the fly camera pose unit and its bind to the top level.
`timescale 1ns / 1ps
`include "fly_camera_pose_update_unit_assert.svh"
module fcp_checker import fcp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input pos_type rsp_pos_x
);
   `FCP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pos_x), "stalled response changed")
   `FCP_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "ready right after a request")
   `FCP_ASSERT_THEN(a_busy_two, req_valid && req_ready, ##2 (!req_ready), "ready two cycles after a request")
endmodule

bind fly_camera_pose_update_unit fcp_checker u_fcp_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_ch.valid),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_pos_x(rsp_ch.pos_x)
);
